### rtl/rsc_pkg.sv
package rsc_pkg;

    // Fixed field widths
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int SIZE_W      = 5;

    // Digit tables: 16 byte entries, low word then high word
    localparam int TABLE_DEPTH = 16;
    localparam int TABLE_IDX_W = 4;
    localparam int TABLE_W     = TABLE_DEPTH * CHAR_W;

    localparam int DEFAULT_MAX_BASE = 16;

    // Divider: quotient bits retired per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = VALUE_W / DIV_STEPS;
    localparam int STEP_W     = $clog2(DIV_CYCLES);

    // Digit stack holds one entry per possible output character
    localparam int STACK_DEPTH = VALUE_W;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SRC_DIGITS_LO = 3'd0,
        CFG_SRC_DIGITS_HI = 3'd1,
        CFG_SRC_BASE_SIZE = 3'd2,
        CFG_TGT_DIGITS_LO = 3'd3,
        CFG_TGT_DIGITS_HI = 3'd4,
        CFG_TGT_BASE_SIZE = 3'd5
    } cfg_index_t;

    // Controller to datapath
    typedef struct packed {
        logic acc_en;   // fold accepted digit into accumulator
        logic term;     // terminator taken: move value into divider
        logic div_step; // one divider step
        logic push;     // push remainder, restart divider
        logic pop;      // output beat taken
    } rsc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_digit;
        logic div_last;
        logic quot_zero;
        logic stack_full;
        logic emit_last;
    } rsc_status_t;

    // Byte idx of a 16-entry character table
    function automatic logic [CHAR_W-1:0] table_byte(input logic [TABLE_W-1:0] tbl,
                                                     input logic [TABLE_IDX_W-1:0] idx);
        return tbl[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

### rtl/radix_string_converter.sv
// Digit character: accepted while idle, one per cycle back to back.
// Terminator: accepted, then each output character takes a divider pass
// (at 4 quotient bits per cycle over the 32-bit value) and a stack push; then the
// n characters leave one beat per cycle as m_ready allows; input then reopens.
// Reset (aresetn, synchronous, active low) clears the accumulator and control
// state and sets both digit tables to zero and both base sizes to 2.
module radix_string_converter #(
    parameter int MAX_BASE = rsc_pkg::DEFAULT_MAX_BASE
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rsc_pkg::CHAR_W-1:0]        s_in_char,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rsc_pkg::CHAR_W-1:0]        m_out_char,
    output logic                              m_last_char
);
    import rsc_pkg::*;

    localparam int RW = $clog2(MAX_BASE + 1);

    logic [TABLE_W-1:0] src_table, tgt_table;
    logic [RW-1:0]      src_radix, tgt_radix;
    rsc_cmd_t           cmd;
    rsc_status_t        status;

    rsc_cfg_regs #(.MAX_BASE(MAX_BASE)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .src_table (src_table),
        .src_radix (src_radix),
        .tgt_table (tgt_table),
        .tgt_radix (tgt_radix)
    );

    rsc_datapath #(.MAX_BASE(MAX_BASE)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_in_char   (s_in_char),
        .src_table   (src_table),
        .src_radix   (src_radix),
        .tgt_table   (tgt_table),
        .tgt_radix   (tgt_radix),
        .cmd         (cmd),
        .status      (status),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

    rsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

endmodule

### rtl/rsc_cfg_regs.sv
module rsc_cfg_regs #(
    parameter int MAX_BASE = rsc_pkg::DEFAULT_MAX_BASE
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [rsc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    output logic [rsc_pkg::TABLE_W-1:0]            src_table,
    output logic [$clog2(MAX_BASE+1)-1:0]          src_radix,
    output logic [rsc_pkg::TABLE_W-1:0]            tgt_table,
    output logic [$clog2(MAX_BASE+1)-1:0]          tgt_radix
);
    import rsc_pkg::*;

    localparam int RW = $clog2(MAX_BASE + 1);
    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_BASE);
    localparam logic [SIZE_W-1:0] MIN_TGT  = SIZE_W'(2);

    logic [CFG_DATA_W-1:0] src_lo_reg, src_hi_reg, tgt_lo_reg, tgt_hi_reg;
    logic [SIZE_W-1:0]     src_size_reg, tgt_size_reg;
    logic [SIZE_W-1:0]     tgt_size_sat;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_lo_reg   <= '0;
            src_hi_reg   <= '0;
            src_size_reg <= SIZE_W'(2);
            tgt_lo_reg   <= '0;
            tgt_hi_reg   <= '0;
            tgt_size_reg <= SIZE_W'(2);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SRC_DIGITS_LO: src_lo_reg   <= cfg_wdata;
                CFG_SRC_DIGITS_HI: src_hi_reg   <= cfg_wdata;
                CFG_SRC_BASE_SIZE: src_size_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_TGT_DIGITS_LO: tgt_lo_reg   <= cfg_wdata;
                CFG_TGT_DIGITS_HI: tgt_hi_reg   <= cfg_wdata;
                CFG_TGT_BASE_SIZE: tgt_size_reg <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign src_table = {src_hi_reg, src_lo_reg};
    assign tgt_table = {tgt_hi_reg, tgt_lo_reg};

    // Radix saturation: source may be 0 or 1, target at least 2
    assign src_radix = (src_size_reg > MAX_SIZE) ? RW'(MAX_SIZE) : RW'(src_size_reg);

    always_comb begin
        tgt_size_sat = tgt_size_reg;
        if (tgt_size_reg < MIN_TGT) begin
            tgt_size_sat = MIN_TGT;
        end else if (tgt_size_reg > MAX_SIZE) begin
            tgt_size_sat = MAX_SIZE;
        end
    end

    assign tgt_radix = RW'(tgt_size_sat);

endmodule

### rtl/rsc_datapath.sv
module rsc_datapath #(
    parameter int MAX_BASE = rsc_pkg::DEFAULT_MAX_BASE
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [rsc_pkg::CHAR_W-1:0]             s_in_char,
    input  logic [rsc_pkg::TABLE_W-1:0]            src_table,
    input  logic [$clog2(MAX_BASE+1)-1:0]          src_radix,
    input  logic [rsc_pkg::TABLE_W-1:0]            tgt_table,
    input  logic [$clog2(MAX_BASE+1)-1:0]          tgt_radix,
    input  rsc_pkg::rsc_cmd_t                      cmd,
    output rsc_pkg::rsc_status_t                   status,
    output logic [rsc_pkg::CHAR_W-1:0]             m_out_char,
    output logic                                   m_last_char
);
    import rsc_pkg::*;

    localparam int RW = $clog2(MAX_BASE + 1);
    localparam int DW = $clog2(MAX_BASE);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_CYCLES - 1);

    logic [VALUE_W-1:0]     acc_reg, acc_next;
    logic [VALUE_W-1:0]     q_reg, q_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STACK_IDX_W-1:0] cnt_reg;
    logic [STACK_IDX_W-1:0] ptr_reg;
    logic [DW-1:0]          stack_reg [STACK_DEPTH];

    logic                   found;
    logic [DW-1:0]          digit;
    logic [DW:0]            tb_ext;
    logic [DW:0]            trial;
    logic [DW-1:0]          out_digit;

    // Source table search, lowest matching index wins
    always_comb begin
        found = 1'b0;
        digit = '0;
        for (int i = MAX_BASE - 1; i >= 0; i--) begin
            if ((s_in_char != '0) && (RW'(i) < src_radix) &&
                (table_byte(src_table, TABLE_IDX_W'(i)) == s_in_char)) begin
                found = 1'b1;
                digit = DW'(i);
            end
        end
    end

    // Multiply-add, wraps at 32 bits
    assign acc_next = VALUE_W'(acc_reg * src_radix) + VALUE_W'(digit);

    // Restoring division, DIV_STEPS quotient bits per cycle
    assign tb_ext = (DW + 1)'(tgt_radix);

    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial  = {rem_next, q_next[VALUE_W-1]};
            q_next = {q_next[VALUE_W-2:0], 1'b0};
            if (trial >= tb_ext) begin
                trial     = trial - tb_ext;
                q_next[0] = 1'b1;
            end
            rem_next = trial[DW-1:0];
        end
    end

    // Accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_next;
        end else if (cmd.term) begin
            acc_reg <= '0;
        end
    end

    // Divider state and digit counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            cnt_reg  <= '0;
            ptr_reg  <= '0;
        end else begin
            if (cmd.term || cmd.push) begin
                step_reg <= '0;
            end else if (cmd.div_step) begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.term) begin
                cnt_reg <= '0;
            end else if (cmd.push) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.push) begin
                ptr_reg <= cnt_reg;
            end else if (cmd.pop) begin
                ptr_reg <= ptr_reg - 1'b1;
            end
        end
    end

    // Quotient/remainder and digit stack
    always_ff @(posedge aclk) begin
        if (cmd.term) begin
            q_reg <= acc_reg;
        end else if (cmd.div_step) begin
            q_reg <= q_next;
        end
        if (cmd.term || cmd.push) begin
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
        end
        if (cmd.push) begin
            stack_reg[cnt_reg] <= rem_reg;
        end
    end

    // Output character, most significant digit sits on top of the stack
    assign out_digit   = stack_reg[ptr_reg];
    assign m_out_char  = table_byte(tgt_table, TABLE_IDX_W'(out_digit));
    assign m_last_char = (ptr_reg == '0);

    // Status to controller
    assign status.is_digit   = found;
    assign status.div_last   = (step_reg == STEP_LAST);
    assign status.quot_zero  = (q_reg == '0);
    assign status.stack_full = (cnt_reg == '1);
    assign status.emit_last  = (ptr_reg == '0);

endmodule

### rtl/rsc_ctrl.sv
module rsc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  rsc_pkg::rsc_status_t  status,
    output rsc_pkg::rsc_cmd_t     cmd
);
    import rsc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (status.is_digit) begin
                        cmd.acc_en = 1'b1;
                    end else begin
                        cmd.term   = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                cmd.push = 1'b1;
                if (status.quot_zero || status.stack_full) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.pop = 1'b1;
                    if (status.emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
